// File: src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and sizes for the windowed sensor statistics core.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int AVERAGE_SPAN  = 10;
  localparam int KIND_COUNT    = 16;

  localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W   = HIST_AW + 1;
  localparam int KIND_W   = 4;
  localparam int SUM_W    = 32 + FILL_W;          // signed sum of up to a full ring
  localparam int MAG_W    = SUM_W + 1;            // |n*v - sum|
  localparam int HALF_W   = (MAG_W + 1) / 2;      // multiplier operand width
  localparam int ACC_W    = 2 * MAG_W + FILL_W - 1;
  localparam int DEN_W    = 3 * (FILL_W - 1) + 1; // holds count cubed
  localparam int ROOT_W   = ACC_W / 2;
  localparam int DIVC_W   = $clog2(ACC_W + 1);
  localparam int SQC_W    = $clog2(ROOT_W + 1);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic [3:0]         sensor_type;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic [31:0]        time_window;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] running_average;
    logic [6:0]         match_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] mean_value;
    logic [31:0]        std_deviation;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic [KIND_W-1:0]  kind;
    logic signed [31:0] value;
  } entry_t;

endpackage

// File: src/wss_in_if.sv
// ----------------------------------------------------------------------------
// wss_in_if
// Input channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface wss_in_if;
  logic              valid;
  logic              ready;
  wss_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/wss_out_if.sv
// ----------------------------------------------------------------------------
// wss_out_if
// Output channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface wss_out_if;
  logic               valid;
  logic               ready;
  wss_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/windowed_sensor_statistics_core.sv
// ----------------------------------------------------------------------------
// windowed_sensor_statistics_core
// Sample history with rolling mean and windowed min/max/mean/std statistics.
// ----------------------------------------------------------------------------
// One item is handled at a time; in.ready is high only while the sequencer is
// idle. A push walks back over up to nine stored entries, each read through
// the registered memory port, and then runs the shared divider. A query reads
// the newest entry, walks the whole fill, divides for the mean, walks again
// (with multiplier steps per matching entry), forms count cubed, divides and
// takes the square root; if nothing matches, it goes straight to the result
// after the first walk. Most of the time goes into the bit-serial divider and
// root units and the single memory port.
// ----------------------------------------------------------------------------
module windowed_sensor_statistics_core (
  input  logic         clk,
  input  logic         rst,
  wss_in_if.sink       in_ch,
  wss_out_if.source    out_ch
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_ACC  = 8'b00000100,
    S_MUL  = 8'b00001000,
    S_CUBE = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_SQRT = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  typedef enum logic [3:0] {
    P_PUSH   = 4'b0001,
    P_NEWEST = 4'b0010,
    P_STATS  = 4'b0100,
    P_VAR    = 4'b1000
  } phase_t;

  localparam int AW = wss_pkg::HIST_AW;
  localparam int FW = wss_pkg::FILL_W;
  localparam int SW = wss_pkg::SUM_W;
  localparam int MW = wss_pkg::MAG_W;
  localparam int HW = wss_pkg::HALF_W;
  localparam int CW = wss_pkg::ACC_W;
  localparam int DW = wss_pkg::DEN_W;

  state_t state;
  phase_t phase;

  // latched item
  logic                        cmd_q;
  logic [wss_pkg::KIND_W-1:0]  kind_q;
  logic [31:0]                 time_q;
  logic signed [31:0]          value_q;
  logic [31:0]                 win_q;

  // ring bookkeeping
  logic [AW-1:0]               write_slot;
  logic [FW-1:0]               fill_level;
  logic signed [31:0]          rolling_mean;

  // working registers
  logic [FW-1:0]               k;
  logic [FW-1:0]               limit;
  logic [FW-1:0]               cnt;
  logic signed [SW-1:0]        sum;
  logic signed [31:0]          mn;
  logic signed [31:0]          mx;
  logic signed [31:0]          mean_q;
  logic signed [33:0]          start;
  logic [MW-1:0]               mag;
  logic [CW-1:0]               acc;
  logic [1:0]                  mstep;
  logic [DW-1:0]               cube;
  logic [31:0]                 sd_q;

  // shared unit hookup
  logic                        div_go;
  logic [CW-1:0]               div_num;
  logic [DW-1:0]               div_den;
  logic                        div_neg;
  logic                        div_done;
  logic [CW-1:0]               div_quo;
  logic                        sq_go;
  logic                        sq_done;
  logic [wss_pkg::ROOT_W-1:0]  sq_root;

  logic                        out_valid;
  wss_pkg::out_item_t          out_data;

  // history memory
  logic                        mem_we;
  wss_pkg::entry_t             mem_wdata;
  logic [AW-1:0]               mem_raddr;
  wss_pkg::entry_t             ent;

  // combinational helpers
  logic                        kind_hit;
  logic                        time_hit;
  logic                        last_entry;
  logic [FW-1:0]               k_inc;
  logic [FW-1:0]               cnt_inc;
  logic signed [SW-1:0]        sum_add;
  logic signed [MW:0]          nv;
  logic signed [MW:0]          dev;
  logic [HW-1:0]               mul_a;
  logic [HW-1:0]               mul_b;
  logic [2*HW-1:0]             prod;
  logic [FW-1:0]               span_m;
  logic signed [31:0]          div_res;
  logic                        show;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign mem_raddr = write_slot - AW'(1) - k[AW-1:0];
  assign mem_we    = (state == S_DIV) && div_done && (phase == P_PUSH);
  assign mem_wdata = '{stamp: time_q, kind: kind_q, value: value_q};

  wss_history u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_slot),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  wss_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  wss_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (acc),
    .done     (sq_done),
    .root     (sq_root)
  );

  // rolling mean looks at most AVERAGE_SPAN-1 older entries
  always_comb begin
    if (fill_level < FW'(wss_pkg::AVERAGE_SPAN - 1)) begin
      span_m = fill_level;
    end else begin
      span_m = FW'(wss_pkg::AVERAGE_SPAN - 1);
    end
  end

  assign kind_hit   = (ent.kind == kind_q);
  assign time_hit   = $signed({2'b00, ent.stamp}) >= start;
  assign k_inc      = k + 1'b1;
  assign cnt_inc    = cnt + 1'b1;
  assign sum_add    = sum + SW'(ent.value);
  assign last_entry = (phase == P_PUSH) ? (k_inc == limit) : (k_inc == fill_level);

  // deviation scaled by count: n*v - sum
  assign nv  = $signed({{(MW+1-FW){1'b0}}, cnt}) * $signed((MW+1)'(ent.value));
  assign dev = nv - (MW+1)'(sum);

  // shared multiplier: square halves of the deviation, or build count cubed
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CUBE) begin
      mul_a = HW'(cnt);
      mul_b = (mstep == 2'd0) ? HW'(cnt) : HW'(cube);
    end else begin
      case (mstep)
        2'd0: begin
          mul_a = HW'(mag[MW-1:HW]);
          mul_b = HW'(mag[MW-1:HW]);
        end
        2'd1: begin
          mul_a = HW'(mag[MW-1:HW]);
          mul_b = mag[HW-1:0];
        end
        default: begin
          mul_a = mag[HW-1:0];
          mul_b = mag[HW-1:0];
        end
      endcase
    end
  end
  assign prod = mul_a * mul_b;

  assign div_res = div_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
  assign show    = (cmd_q == wss_pkg::CMD_QUERY) && (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= P_PUSH;
      write_slot   <= '0;
      fill_level   <= '0;
      rolling_mean <= '0;
      out_valid    <= 1'b0;
      div_go       <= 1'b0;
      sq_go        <= 1'b0;
    end else begin
      // result register: load in S_OUT, drop once taken
      if (state == S_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_q   <= in_ch.data.command;
            kind_q  <= wss_pkg::KIND_W'(in_ch.data.sensor_type % wss_pkg::KIND_COUNT);
            time_q  <= in_ch.data.sample_time;
            value_q <= in_ch.data.sample_value;
            win_q   <= in_ch.data.time_window;
            k       <= '0;
            mstep   <= '0;
            if (in_ch.data.command == wss_pkg::CMD_PUSH) begin
              phase <= P_PUSH;
              limit <= span_m;
              sum   <= SW'(in_ch.data.sample_value);
              cnt   <= FW'(1);
              if (span_m == '0) begin
                div_go  <= 1'b1;
                div_num <= CW'(in_ch.data.sample_value[31] ?
                               -SW'(in_ch.data.sample_value) :
                               SW'(in_ch.data.sample_value));
                div_den <= DW'(1);
                div_neg <= in_ch.data.sample_value[31];
                state   <= S_DIV;
              end else begin
                state <= S_RD;
              end
            end else begin
              cnt <= '0;
              if (fill_level == '0) begin
                state <= S_OUT;       // empty history: all statistics zero
              end else begin
                phase <= P_NEWEST;
                state <= S_RD;
              end
            end
          end
        end

        S_RD: begin
          state <= S_ACC;
        end

        S_ACC: begin
          case (phase)
            P_PUSH: begin
              if (kind_hit) begin
                sum <= sum_add;
                cnt <= cnt_inc;
              end
              k <= k_inc;
              if (last_entry) begin
                div_go  <= 1'b1;
                div_num <= CW'(kind_hit ? (sum_add < 0 ? -sum_add : sum_add)
                                        : (sum < 0 ? -sum : sum));
                div_den <= DW'(kind_hit ? cnt_inc : cnt);
                div_neg <= kind_hit ? sum_add[SW-1] : sum[SW-1];
                state   <= S_DIV;
              end else begin
                state <= S_RD;
              end
            end
            P_NEWEST: begin
              // window start may go negative: then every entry passes
              if (win_q == '0) begin
                start <= '0;
              end else begin
                start <= $signed({2'b00, ent.stamp}) - $signed({2'b00, win_q});
              end
              sum   <= '0;
              cnt   <= '0;
              k     <= '0;
              phase <= P_STATS;
              state <= S_RD;
            end
            P_STATS: begin
              if (kind_hit && time_hit) begin
                if (cnt == '0 || ent.value < mn) mn <= ent.value;
                if (cnt == '0 || ent.value > mx) mx <= ent.value;
                sum <= sum_add;
                cnt <= cnt_inc;
              end
              k <= k_inc;
              if (last_entry) begin
                if (cnt == '0 && !(kind_hit && time_hit)) begin
                  state <= S_OUT;
                end else begin
                  div_go  <= 1'b1;
                  div_num <= CW'((kind_hit && time_hit) ?
                                 (sum_add < 0 ? -sum_add : sum_add) :
                                 (sum < 0 ? -sum : sum));
                  div_den <= DW'((kind_hit && time_hit) ? cnt_inc : cnt);
                  div_neg <= (kind_hit && time_hit) ? sum_add[SW-1] : sum[SW-1];
                  state   <= S_DIV;
                end
              end else begin
                state <= S_RD;
              end
            end
            default: begin // P_VAR
              if (kind_hit && time_hit) begin
                mag   <= dev[MW] ? MW'(-dev) : MW'(dev);
                mstep <= '0;
                state <= S_MUL;
              end else begin
                k <= k_inc;
                if (last_entry) begin
                  mstep <= '0;
                  state <= S_CUBE;
                end else begin
                  state <= S_RD;
                end
              end
            end
          endcase
        end

        S_MUL: begin
          case (mstep)
            2'd0: acc <= acc + (CW'(prod) << (2 * HW));
            2'd1: acc <= acc + (CW'(prod) << (HW + 1));
            default: acc <= acc + CW'(prod);
          endcase
          if (mstep == 2'd2) begin
            mstep <= '0;
            k     <= k_inc;
            state <= last_entry ? S_CUBE : S_RD;
          end else begin
            mstep <= mstep + 1'b1;
          end
        end

        S_CUBE: begin
          cube <= DW'(prod);
          if (mstep == 2'd0) begin
            mstep <= 2'd1;
          end else begin
            // variance = acc / n^3 in raw units squared
            mstep   <= '0;
            div_go  <= 1'b1;
            div_num <= acc;
            div_den <= DW'(prod);
            div_neg <= 1'b0;
            state   <= S_DIV;
          end
        end

        S_DIV: begin
          div_go <= 1'b0;     // start strobe lasts one cycle
          if (div_done) begin
            case (phase)
              P_PUSH: begin
                rolling_mean <= div_res;
                write_slot   <= write_slot + 1'b1;
                if (fill_level != FW'(wss_pkg::HISTORY_DEPTH)) begin
                  fill_level <= fill_level + 1'b1;
                end
                state <= S_OUT;
              end
              P_STATS: begin
                mean_q <= div_res;
                acc    <= '0;
                k      <= '0;
                phase  <= P_VAR;
                state  <= S_RD;
              end
              default: begin
                acc   <= div_quo;
                sq_go <= 1'b1;
                state <= S_SQRT;
              end
            endcase
          end
        end

        S_SQRT: begin
          sq_go <= 1'b0;
          if (sq_done) begin
            sd_q  <= sq_root[31:0];
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_data.running_average <= rolling_mean;
            out_data.match_count     <= show ? 7'(cnt) : '0;
            out_data.min_value       <= show ? mn : '0;
            out_data.max_value       <= show ? mx : '0;
            out_data.mean_value      <= show ? mean_q : '0;
            out_data.std_deviation   <= show ? sd_q : '0;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/wss_history.sv
// ----------------------------------------------------------------------------
// wss_history
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wss_history (
  input  logic                         clk,
  input  logic                         we,
  input  logic [wss_pkg::HIST_AW-1:0]  waddr,
  input  wss_pkg::entry_t              wdata,
  input  logic [wss_pkg::HIST_AW-1:0]  raddr,
  output wss_pkg::entry_t              rdata
);

  wss_pkg::entry_t mem [wss_pkg::HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/wss_divider.sv
// ----------------------------------------------------------------------------
// wss_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wss_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [wss_pkg::ACC_W-1:0]  num,
  input  logic [wss_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [wss_pkg::ACC_W-1:0]  quo
);

  logic [wss_pkg::DEN_W-1:0]  rem;
  logic [wss_pkg::DEN_W-1:0]  den_q;
  logic [wss_pkg::DIVC_W-1:0] cnt;
  logic                       busy;
  logic [wss_pkg::DEN_W:0]    shifted;
  logic                       fits;

  assign shifted = {rem, quo[wss_pkg::ACC_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (go) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        cnt   <= wss_pkg::DIVC_W'(wss_pkg::ACC_W);
        quo   <= num;
        den_q <= den;
        rem   <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= wss_pkg::DEN_W'(shifted - {1'b0, den_q});
        end else begin
          rem <= shifted[wss_pkg::DEN_W-1:0];
        end
        quo  <= {quo[wss_pkg::ACC_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        done <= (cnt == wss_pkg::DIVC_W'(1));
        if (cnt == wss_pkg::DIVC_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// File: src/wss_sqrt.sv
// ----------------------------------------------------------------------------
// wss_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module wss_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [wss_pkg::ACC_W-1:0]   radicand,
  output logic                        done,
  output logic [wss_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = wss_pkg::ROOT_W + 3;

  logic [wss_pkg::ACC_W-1:0]  x;
  logic [REM_W-1:0]           rem;
  logic [wss_pkg::SQC_W-1:0]  cnt;
  logic                       busy;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;

  assign rem_sh = {rem[REM_W-3:0], x[wss_pkg::ACC_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (go) begin
        done <= 1'b0;
        busy <= 1'b1;
        cnt  <= wss_pkg::SQC_W'(wss_pkg::ROOT_W);
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[wss_pkg::ACC_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[wss_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[wss_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt  <= cnt - 1'b1;
        done <= (cnt == wss_pkg::SQC_W'(1));
        if (cnt == wss_pkg::SQC_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// File: test/tb_windowed_sensor_statistics_core.sv
// ----------------------------------------------------------------------------
// tb_windowed_sensor_statistics_core
// Self-checking bench: a table of directed items, then random pushes and
// queries. Every result is compared with a behavioral model of the history
// ring, the rolling mean and the windowed statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_windowed_sensor_statistics_core;

  logic clk;
  logic rst;

  wss_in_if  in_ch ();
  wss_out_if out_ch ();

  windowed_sensor_statistics_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state: the ring, write pointer, fill and rolling mean.
  logic [31:0]        hist_time  [wss_pkg::HISTORY_DEPTH];
  logic [3:0]         hist_kind  [wss_pkg::HISTORY_DEPTH];
  logic signed [31:0] hist_value [wss_pkg::HISTORY_DEPTH];
  int                 wr_slot;
  int                 fill;
  logic signed [31:0] avg_state;

  wss_pkg::out_item_t pending_results [$];
  bit                 failed;

  // Directed table; check_direct marks rows whose result is typed in.
  typedef struct {
    wss_pkg::in_item_t  item;
    bit                 check_direct;
    wss_pkg::out_item_t result;
  } row_t;

  function automatic int back_slot(int k);
    return (wr_slot + wss_pkg::HISTORY_DEPTH - 1 - k) % wss_pkg::HISTORY_DEPTH;
  endfunction

  // Integer square root of a 160-bit value whose root fits in 41 bits.
  function automatic logic [63:0] isqrt(logic [159:0] a);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [159:0] sq;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {96'd0, c} * {96'd0, c};
      if (sq <= a) r = c;
    end
    return r;
  endfunction

  function automatic wss_pkg::out_item_t compute_stats(wss_pkg::in_item_t it);
    wss_pkg::out_item_t r;
    longint           sum;
    longint           n;
    longint           v;
    longint           start;
    longint           mn;
    longint           mx;
    longint           d;
    longint           cnt;
    logic [159:0]     acc;
    logic [159:0]     mag;
    int               m;
    int               s;
    r = '0;
    mn = 0;
    mx = 0;
    cnt = 0;
    if (it.command == wss_pkg::CMD_PUSH) begin
      v = it.sample_value;
      sum = v;
      n = 1;
      m = (fill < wss_pkg::AVERAGE_SPAN - 1) ? fill : wss_pkg::AVERAGE_SPAN - 1;
      for (int k = 0; k < m; k++) begin
        s = back_slot(k);
        if (hist_kind[s] == it.sensor_type) begin
          sum += hist_value[s];
          n++;
        end
      end
      avg_state = 32'(sum / n);
      hist_time[wr_slot]  = it.sample_time;
      hist_kind[wr_slot]  = it.sensor_type;
      hist_value[wr_slot] = it.sample_value;
      wr_slot = (wr_slot + 1) % wss_pkg::HISTORY_DEPTH;
      if (fill < wss_pkg::HISTORY_DEPTH) fill++;
    end else if (fill > 0) begin
      // Start may go negative: then every entry of the kind passes.
      start = (it.time_window != 0) ?
              longint'(hist_time[back_slot(0)]) - longint'(it.time_window) : 0;
      sum = 0;
      for (int k = 0; k < fill; k++) begin
        s = back_slot(k);
        if (hist_kind[s] == it.sensor_type && longint'(hist_time[s]) >= start) begin
          v = hist_value[s];
          if (cnt == 0 || v < mn) mn = v;
          if (cnt == 0 || v > mx) mx = v;
          sum += v;
          cnt++;
        end
      end
      if (cnt > 0) begin
        acc = '0;
        for (int k = 0; k < fill; k++) begin
          s = back_slot(k);
          if (hist_kind[s] == it.sensor_type && longint'(hist_time[s]) >= start) begin
            d = cnt * longint'(hist_value[s]) - sum;
            mag = (d < 0) ? 160'(-d) : 160'(d);
            acc += mag * mag;
          end
        end
        // variance = acc / n^3; successive floors equal one floor
        acc = acc / 160'(cnt * cnt * cnt);
        r.std_deviation = 32'(isqrt(acc));
        r.mean_value    = 32'(sum / cnt);
      end
    end
    r.running_average = avg_state;
    r.match_count     = 7'(cnt);
    r.min_value       = 32'(mn);
    r.max_value       = 32'(mx);
    return r;
  endfunction

  function automatic wss_pkg::in_item_t mk(logic cmd, logic [3:0] kind, logic [31:0] t,
                                           logic [31:0] v, logic [31:0] w);
    wss_pkg::in_item_t it;
    it.command      = cmd;
    it.sensor_type  = kind;
    it.sample_time  = t;
    it.sample_value = v;
    it.time_window  = w;
    return it;
  endfunction

  // Pushes mostly use a few kinds and rising timestamps so windows bite.
  logic [31:0] clock_ticks;

  function automatic wss_pkg::in_item_t rand_item();
    wss_pkg::in_item_t it;
    it = mk($urandom_range(0, 99) < 55 ? wss_pkg::CMD_PUSH : wss_pkg::CMD_QUERY,
            '0, '0, '0, '0);
    it.sensor_type = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: it.sample_time = $urandom;
      default: begin
        clock_ticks += $urandom_range(0, 40);
        it.sample_time = clock_ticks;
      end
    endcase
    case ($urandom_range(0, 3))
      0: it.sample_value = $urandom;
      1: it.sample_value = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                : 32'h8000_0000 + $urandom_range(0, 3);
      default: it.sample_value = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
    case ($urandom_range(0, 3))
      0: it.time_window = 0;
      1: it.time_window = $urandom;
      default: it.time_window = $urandom_range(1, 400);
    endcase
    return it;
  endfunction

  row_t rows [$];
  wss_pkg::out_item_t zero_res;

  task automatic add_row(wss_pkg::in_item_t it, bit chk, wss_pkg::out_item_t res);
    row_t r;
    r.item         = it;
    r.check_direct = chk;
    r.result       = res;
    rows = {rows, r};
  endtask

  // Valid stays high into the next item when no idle cycles are drawn.
  task automatic send(wss_pkg::in_item_t it);
    int                 gap;
    wss_pkg::out_item_t exp_item;
    gap = $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_item = compute_stats(it);
    pending_results = {pending_results, exp_item};
    @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    row_t rw;
    wss_pkg::out_item_t e;
    failed = 0;
    wr_slot = 0;
    fill = 0;
    avg_state = 0;
    clock_ticks = 0;
    zero_res = '0;
    for (int i = 0; i < wss_pkg::HISTORY_DEPTH; i++) begin
      hist_time[i] = '0;
      hist_kind[i] = '0;
      hist_value[i] = '0;
    end
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Query on empty history: all zero.
    add_row(mk(wss_pkg::CMD_QUERY, 4'd3, 32'd0, 32'd0, 32'd0), 1, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd15, '1, '1, '1), 1, zero_res);
    // First push of an extreme returns itself as the rolling mean.
    e = zero_res; e.running_average = 32'h7fff_ffff;
    add_row(mk(wss_pkg::CMD_PUSH, 4'd15, '1, 32'h7fff_ffff, '1), 1, e);
    e = zero_res; e.running_average = 32'h8000_0000;
    add_row(mk(wss_pkg::CMD_PUSH, 4'd0, 32'd0, 32'h8000_0000, 32'd0), 1, e);
    // Kind 15 has a single max entry: stats read off directly.
    e = '{32'h8000_0000, 7'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0};
    add_row(mk(wss_pkg::CMD_QUERY, 4'd15, 32'd5, 32'd5, 32'd0), 1, e);
    // Rounding toward zero of the rolling mean for negative sums.
    add_row(mk(wss_pkg::CMD_PUSH, 4'd0, 32'd10, 32'h0000_0003, 32'd0), 0, zero_res);
    add_row(mk(wss_pkg::CMD_PUSH, 4'd7, 32'd20, 32'hffff_fffd, 32'd0), 0, zero_res);
    add_row(mk(wss_pkg::CMD_PUSH, 4'd7, 32'd30, 32'h0000_0000, 32'd0), 0, zero_res);
    // Windows: wrap below zero, narrow, exact edge, whole history.
    add_row(mk(wss_pkg::CMD_QUERY, 4'd7, 32'd0, 32'd0, '1), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd7, 32'd0, 32'd0, 32'd10), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd7, 32'd0, 32'd0, 32'd1), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd0, 32'd0, 32'd0, 32'd0), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd9, 32'd0, 32'd0, 32'd0), 0, zero_res);
    add_row(mk(wss_pkg::CMD_PUSH, 4'd0, 32'hffff_ffff, 32'h8000_0000, 32'd0), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd0, 32'd0, 32'd0, 32'h8000_0000), 0, zero_res);
    add_row(mk(wss_pkg::CMD_QUERY, 4'd0, 32'd0, 32'd0, 32'hffff_fffe), 0, zero_res);

    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.item);
      if (rw.check_direct && pending_results[$] != rw.result) begin
        $display("%0t: table row %0d model disagrees: exp %h got %h",
                 $time, i, rw.result, pending_results[$]);
        failed = 1;
      end
      if (rw.check_direct) pending_results[$] = rw.result;
    end

    // Random part; some long push runs fill and wrap the ring.
    for (int i = 0; i < 900; i++) send(rand_item());
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed) begin
      $display("tb_windowed_sensor_statistics_core passed");
    end else begin
      $display("tb_windowed_sensor_statistics_core failed");
    end
    $finish;
  end

  // Output side: random stalls, compare against the oldest expectation.
  initial begin
    wss_pkg::out_item_t exp_r;
    int                 gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 16);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.data);
        failed = 1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.data.running_average !== exp_r.running_average) begin
          $display("%0t: running_average exp %h got %h", $time,
                   exp_r.running_average, out_ch.data.running_average);
          failed = 1;
        end
        if (out_ch.data.match_count !== exp_r.match_count) begin
          $display("%0t: match_count exp %0d got %0d", $time,
                   exp_r.match_count, out_ch.data.match_count);
          failed = 1;
        end
        if (out_ch.data.min_value !== exp_r.min_value) begin
          $display("%0t: min_value exp %h got %h", $time,
                   exp_r.min_value, out_ch.data.min_value);
          failed = 1;
        end
        if (out_ch.data.max_value !== exp_r.max_value) begin
          $display("%0t: max_value exp %h got %h", $time,
                   exp_r.max_value, out_ch.data.max_value);
          failed = 1;
        end
        if (out_ch.data.mean_value !== exp_r.mean_value) begin
          $display("%0t: mean_value exp %h got %h", $time,
                   exp_r.mean_value, out_ch.data.mean_value);
          failed = 1;
        end
        if (out_ch.data.std_deviation !== exp_r.std_deviation) begin
          $display("%0t: std_deviation exp %h got %h", $time,
                   exp_r.std_deviation, out_ch.data.std_deviation);
          failed = 1;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: fails the run if the ~920 items hang.
  initial begin
    #20ms;
    $display("tb_windowed_sensor_statistics_core failed");
    $finish;
  end

endmodule
